/* design/dmwtc_pkg.sv */
// shared types, constants and helpers for the direct-mapped write-through cache
package dmwtc_pkg;

  localparam int LINES       = 64;
  localparam int BLOCK_BYTES = 8;
  localparam int ADDR_W      = 32;
  localparam int DATA_W      = 64;
  localparam int CNT_W       = 4;
  localparam int LANES       = DATA_W / 8;
  localparam int OFF_W       = $clog2(BLOCK_BYTES);
  localparam int IDX_W       = $clog2(LINES);
  localparam int TAG_W       = ADDR_W - OFF_W - IDX_W;
  localparam int CHIP_W      = 8;

  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  // register index, taken from paddr[2]
  localparam logic REG_LOCAL_CHIP_ID = 1'b0;

  // input op codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FILL  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_READ_HIT  = 3'd0;
  localparam logic [2:0] KIND_BLOCK_REQ = 3'd1;
  localparam logic [2:0] KIND_FILL_DATA = 3'd2;
  localparam logic [2:0] KIND_MEM_WRITE = 3'd3;
  localparam logic [2:0] KIND_FORWARD   = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_ACCESS
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;  // capture request and read the line memory
    logic issue;   // commit the line update and load the result register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_valid;
    logic op_none;
    logic slot_free;
  } ctrl_status_t;

  // byte lanes off .. off+len-1 set, clipped to the word
  function automatic logic [DATA_W-1:0] lane_mask(input logic [OFF_W-1:0] off,
                                                  input logic [CNT_W-1:0] len);
    logic [DATA_W-1:0] m;
    logic [CNT_W:0]    lo;
    logic [CNT_W:0]    hi;
    m  = '0;
    lo = (CNT_W+1)'(off);
    hi = (CNT_W+1)'(off) + (CNT_W+1)'(len);
    for (int i = 0; i < LANES; i++) begin
      if ((CNT_W+1)'(i) >= lo && (CNT_W+1)'(i) < hi) begin
        m[8*i +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

/* design/direct_mapped_write_through_cache.sv */
// Direct-mapped, write-through, no-write-allocate cache with 64 lines of 8 bytes.
// Each request transaction is one segment that lies inside a single block, or a fill that
// returns a block from memory; each gives exactly one result transaction (op 3 gives none).
// An item first reads the single-port line memory (tag and data in one word, registered
// read), then decides the result and writes the line back. The block takes no new request
// until the current result is issued; a new request is taken while the previous result
// still sits in the output register. Line valid bits and per-line touched marks are
// flip-flops cleared by reset, so the block needs no clearing pass and works right after
// reset. local_chip_id sits at byte address 0 of the APB port and must only be written
// while the block is idle.
module direct_mapped_write_through_cache (
  input  logic                                clk,
  input  logic                                rst,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dmwtc_pkg::PADDR_W-1:0]       paddr,
  input  logic [dmwtc_pkg::PDATA_W-1:0]       pwdata,
  output logic [dmwtc_pkg::PDATA_W-1:0]       prdata,
  output logic                                pready,
  // request channel
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [1:0]                          op,
  input  logic [dmwtc_pkg::ADDR_W-1:0]        byte_address,
  input  logic [dmwtc_pkg::CNT_W-1:0]         byte_count,
  input  logic [dmwtc_pkg::DATA_W-1:0]        payload,
  input  logic                                first_segment,
  input  logic                                last_segment,
  input  logic                                fixed_addr,
  input  logic                                volatile_flag,
  input  logic [dmwtc_pkg::CHIP_W-1:0]        target_chip,
  // result channel
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [2:0]                          kind,
  output logic                                hit,
  output logic [dmwtc_pkg::ADDR_W-1:0]        out_address,
  output logic [dmwtc_pkg::DATA_W-1:0]        out_data,
  output logic [dmwtc_pkg::CNT_W-1:0]         out_count,
  output logic                                last_write
);
  import dmwtc_pkg::*;

  logic [CHIP_W-1:0] local_chip_id;
  logic              reg_sel;
  ctrl_cmd_t         cmd;
  ctrl_status_t      status;

  // register index is the word address
  assign reg_sel = (paddr[2] == REG_LOCAL_CHIP_ID);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_chip_id <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      local_chip_id <= pwdata[CHIP_W-1:0];
    end
  end

  // reads of unmapped words return zero
  assign prdata = reg_sel ? PDATA_W'(local_chip_id) : '0;

  // sequencing: accept, line lookup, issue
  dmwtc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .status    (status),
    .cmd       (cmd),
    .req_stall (req_stall)
  );

  // line memory, tag compare, merge and result register
  dmwtc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .req_valid     (req_valid),
    .op            (op),
    .byte_address  (byte_address),
    .byte_count    (byte_count),
    .payload       (payload),
    .first_segment (first_segment),
    .last_segment  (last_segment),
    .fixed_addr    (fixed_addr),
    .volatile_flag (volatile_flag),
    .target_chip   (target_chip),
    .local_chip_id (local_chip_id),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .kind          (kind),
    .hit           (hit),
    .out_address   (out_address),
    .out_data      (out_data),
    .out_count     (out_count),
    .last_write    (last_write)
  );

  // a write transaction is taken only with the port's full handshake
  assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && reg_sel |=> local_chip_id == $past(pwdata[CHIP_W-1:0]))
    else $error("chip id write lost");

endmodule

/* design/dmwtc_ctrl.sv */
// controller state machine for the cache: request capture and result issue
module dmwtc_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  dmwtc_pkg::ctrl_status_t status,
  output dmwtc_pkg::ctrl_cmd_t    cmd,
  output logic                    req_stall
);
  import dmwtc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (status.req_valid && !status.op_none) begin
          state_next = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        if (status.slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        req_stall  = 1'b0;
        cmd.accept = status.req_valid;
      end
      ST_ACCESS: begin
        cmd.issue = status.slot_free;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  // any op other than op 3 must go on to the access state
  assert property (@(posedge clk) disable iff (rst)
    cmd.accept && !status.op_none |=> state == ST_ACCESS)
    else $error("accepted request did not enter access state");

  // results leave only from the access state, which then returns to idle
  assert property (@(posedge clk) disable iff (rst)
    cmd.issue |=> state == ST_IDLE)
    else $error("issue did not return to idle");

endmodule

/* design/dmwtc_datapath.sv */
// cache datapath: line memory, valid and touched bits, result register
module dmwtc_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  dmwtc_pkg::ctrl_cmd_t            cmd,
  output dmwtc_pkg::ctrl_status_t         status,
  input  logic                            req_valid,
  input  logic [1:0]                      op,
  input  logic [dmwtc_pkg::ADDR_W-1:0]    byte_address,
  input  logic [dmwtc_pkg::CNT_W-1:0]     byte_count,
  input  logic [dmwtc_pkg::DATA_W-1:0]    payload,
  input  logic                            first_segment,
  input  logic                            last_segment,
  input  logic                            fixed_addr,
  input  logic                            volatile_flag,
  input  logic [dmwtc_pkg::CHIP_W-1:0]    target_chip,
  input  logic [dmwtc_pkg::CHIP_W-1:0]    local_chip_id,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [2:0]                      kind,
  output logic                            hit,
  output logic [dmwtc_pkg::ADDR_W-1:0]    out_address,
  output logic [dmwtc_pkg::DATA_W-1:0]    out_data,
  output logic [dmwtc_pkg::CNT_W-1:0]     out_count,
  output logic                            last_write
);
  import dmwtc_pkg::*;

  localparam int WORD_W = TAG_W + DATA_W;

  // captured request
  logic [1:0]        r_op;
  logic [ADDR_W-1:0] r_addr;
  logic [CNT_W-1:0]  r_cnt;
  logic [DATA_W-1:0] r_payload;
  logic              r_last;
  logic              r_cached;

  logic [WORD_W-1:0] line_mem [LINES];
  logic [WORD_W-1:0] rd_word;
  logic [LINES-1:0]  line_valid;
  logic [LINES-1:0]  touched;

  logic [OFF_W-1:0]  r_off;
  logic [IDX_W-1:0]  r_idx;
  logic [TAG_W-1:0]  r_tag;
  logic [IDX_W-1:0]  in_idx;
  logic [CNT_W-1:0]  cnt_fix;
  logic [CNT_W-1:0]  room;
  logic [CNT_W-1:0]  seg_len;
  logic [DATA_W-1:0] m;
  logic [DATA_W-1:0] rd_bytes;
  logic              hit_c;

  logic              mem_we;
  logic [WORD_W-1:0] mem_wdata;
  logic              set_touch;
  logic [2:0]        kind_next;
  logic              hit_next;
  logic [ADDR_W-1:0] address_next;
  logic [DATA_W-1:0] data_next;
  logic [CNT_W-1:0]  count_next;
  logic              last_next;

  assign status.req_valid = req_valid;
  assign status.op_none   = (op == OP_NONE);
  assign status.slot_free = !rsp_valid || !rsp_stall;

  assign in_idx   = byte_address[OFF_W +: IDX_W];
  assign r_off    = r_addr[OFF_W-1:0];
  assign r_idx    = r_addr[OFF_W +: IDX_W];
  assign r_tag    = r_addr[ADDR_W-1 -: TAG_W];
  assign rd_bytes = rd_word[DATA_W-1:0];

  assign cnt_fix = (r_cnt == '0) ? CNT_W'(1) : r_cnt;
  assign room    = CNT_W'(BLOCK_BYTES) - CNT_W'(r_off);
  assign seg_len = (cnt_fix < room) ? cnt_fix : room;
  assign m       = lane_mask(r_off, seg_len);
  assign hit_c   = line_valid[r_idx] && (rd_word[WORD_W-1 -: TAG_W] == r_tag);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      r_op      <= op;
      r_addr    <= byte_address;
      r_cnt     <= byte_count;
      r_payload <= payload;
      r_last    <= last_segment;
      r_cached  <= fixed_addr && !volatile_flag && (target_chip == local_chip_id);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_word <= line_mem[in_idx];
    end
    if (cmd.issue && mem_we) begin
      line_mem[r_idx] <= mem_wdata;
    end
  end

  always_comb begin
    mem_we       = 1'b0;
    mem_wdata    = {r_tag, r_payload & lane_mask('0, CNT_W'(BLOCK_BYTES))};
    set_touch    = 1'b0;
    kind_next    = KIND_FORWARD;
    hit_next     = 1'b0;
    address_next = r_addr;
    data_next    = '0;
    count_next   = seg_len;
    last_next    = 1'b0;
    if (r_op == OP_FILL) begin
      kind_next = KIND_FILL_DATA;
      data_next = r_payload & m;
      if (!touched[r_idx]) begin
        mem_we    = 1'b1;
        set_touch = 1'b1;
      end
    end else if (!r_cached) begin
      kind_next = KIND_FORWARD;
      if (r_op == OP_WRITE) begin
        data_next = r_payload & m;
      end
    end else if (r_op == OP_READ) begin
      if (hit_c) begin
        kind_next = KIND_READ_HIT;
        hit_next  = 1'b1;
        data_next = rd_bytes & m;
      end else begin
        kind_next    = KIND_BLOCK_REQ;
        address_next = {r_addr[ADDR_W-1:OFF_W], {OFF_W{1'b0}}};
        count_next   = CNT_W'(BLOCK_BYTES);
      end
    end else begin
      kind_next = KIND_MEM_WRITE;
      hit_next  = hit_c;
      data_next = r_payload & m;
      last_next = r_last;
      if (hit_c) begin
        mem_we    = 1'b1;
        mem_wdata = {r_tag, (rd_bytes & ~m) | (r_payload & m)};
        set_touch = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= '0;
      touched    <= '0;
    end else if (cmd.accept) begin
      if (first_segment && (op == OP_READ || op == OP_WRITE)) begin
        touched <= '0;
      end
    end else if (cmd.issue && set_touch) begin
      touched[r_idx]    <= 1'b1;
      line_valid[r_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.issue) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      kind        <= kind_next;
      hit         <= hit_next;
      out_address <= address_next;
      out_data    <= data_next;
      out_count   <= count_next;
      last_write  <= last_next;
    end
  end

  // a block request is never a hit and points at a block start
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && kind == KIND_BLOCK_REQ |-> !hit && out_address[OFF_W-1:0] == '0)
    else $error("malformed block read request");

  // a refill or a write hit leaves its line valid and marked for the transaction
  assert property (@(posedge clk) disable iff (rst)
    cmd.issue && set_touch |=> line_valid[$past(r_idx)] && touched[$past(r_idx)])
    else $error("line update not recorded");

  // the result register is only loaded into an empty or draining slot
  assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !rsp_valid || !rsp_stall)
    else $error("result overwritten while stalled");

endmodule
